// ===== src/grouped_active_set_list_defines.svh =====
// assertion macros for the active set list
`ifndef GROUPED_ACTIVE_SET_LIST_DEFINES_SVH
`define GROUPED_ACTIVE_SET_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define GASL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define GASL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GASL_ASSERT(lbl, clk, rstn, prop, msg)
`define GASL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/gasl_pkg.sv =====
// shared constants and cell control types of the active set list
package gasl_pkg;
    localparam int MAX_VARS   = 256;
    localparam int MAX_GROUPS = 64;
    localparam int VAR_AW     = $clog2(MAX_VARS);
    localparam int GRP_AW     = $clog2(MAX_GROUPS);
    localparam int VAR_CW     = $clog2(MAX_VARS + 1);
    localparam int GRP_CW     = $clog2(MAX_GROUPS + 1);
    localparam int VAR_W      = 8;
    localparam int GRP_W      = 6;
    localparam int COEF_W     = 64;

    typedef enum logic [2:0] {
        ACT_LOAD = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_RMV  = 3'd2,
        ACT_DEF  = 3'd3,
        ACT_GADD = 3'd4,
        ACT_GRMV = 3'd5,
        ACT_READ = 3'd6,
        ACT_NOP  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_ACTIVE = 2'd3
    } status_t;

    typedef struct packed {
        logic              wr;
        logic              sh;
        logic [VAR_AW-1:0] pos;
        logic [VAR_W-1:0]  var_val;
        logic [COEF_W-1:0] coef;
    } vctrl_t;

    typedef struct packed {
        logic              wr;
        logic              sh;
        logic [GRP_AW-1:0] pos;
        logic [GRP_W-1:0]  gid;
    } gctrl_t;
endpackage

// ===== src/grouped_active_set_list.sv =====
// load, add, remove variable, read: executed in S_EXEC, result issued from S_DONE
// define group: one member tag written per cycle
// add group: S_GFETCH reads the group bounds, then S_GADD appends each member not yet active while the list has room
// remove group: each list slot gets a tag lookup (S_SCAN_A), then a shift if it is in the group (S_SCAN_B)
// one transaction at a time, accepted only in S_IDLE; a new one is accepted while a result waits for m_tready
// synchronous active-low reset clears flags, counts and the sequencer; list slots hold junk
`include "grouped_active_set_list_defines.svh"
module grouped_active_set_list (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // var_index, position, group_index, group_size, coefficient, zero pad
    input  logic [95:0]  s_tdata,
    // action
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // active_count, group_count, var_at_position, coef_at_position,
    // group_at_position, var_flag, group_flag
    output logic [95:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser
);
    localparam int NV  = gasl_pkg::MAX_VARS;
    localparam int NG  = gasl_pkg::MAX_GROUPS;
    localparam int VAW = gasl_pkg::VAR_AW;
    localparam int GAW = gasl_pkg::GRP_AW;
    localparam int VCW = gasl_pkg::VAR_CW;
    localparam int GCW = gasl_pkg::GRP_CW;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_DEFINE, S_GFETCH, S_GADD, S_SCAN_A, S_SCAN_B, S_DONE
    } state_t;

    state_t state_reg, state_next;
    gasl_pkg::action_t act_reg, act_next;
    logic [7:0]  vi_reg, vi_next;
    logic [7:0]  pos_reg, pos_next;
    logic [5:0]  gi_reg, gi_next;
    logic [8:0]  gsize_reg, gsize_next;
    logic [63:0] coef_reg, coef_next;
    logic [VCW-1:0] vtot_reg, vtot_next;
    logic [GCW-1:0] gtot_reg, gtot_next;
    logic [VCW-1:0] nstart_reg, nstart_next;
    logic [VCW-1:0] cnt_reg, cnt_next;
    logic [VCW-1:0] end_reg, end_next;
    logic [GAW-1:0] gid_reg, gid_next;
    logic [NV-1:0]  vflags_reg, vflags_next;
    logic [NG-1:0]  gflags_reg, gflags_next;
    gasl_pkg::status_t status_reg, status_next;
    logic [7:0]  rd_var_reg, rd_var_next;
    logic [63:0] rd_coef_reg, rd_coef_next;
    logic [5:0]  rd_grp_reg, rd_grp_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [95:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    gasl_pkg::vctrl_t vctrl;
    gasl_pkg::gctrl_t gctrl;
    logic [gasl_pkg::VAR_W-1:0]  cvar  [NV];
    logic [gasl_pkg::COEF_W-1:0] ccoef [NV];
    logic [gasl_pkg::GRP_W-1:0]  cgid  [NG];

    // group bounds and member tags
    logic [VCW-1:0] gstart_mem [NG];
    logic [VCW-1:0] gend_mem   [NG];
    logic [GAW-1:0] vgid_mem   [NV];
    logic [VCW-1:0] gstart_rd_reg, gend_rd_reg;
    logic [GAW-1:0] vgid_rd_reg;
    logic           gmem_we, vgid_we;
    logic [VAW-1:0] vgid_waddr, vgid_raddr;

    genvar gv;
    generate
        for (gv = 0; gv < NV; gv++) begin : g_vcell
            gasl_var_cell u_cell (
                .aclk     (aclk),
                .ctrl     (vctrl),
                .my_index (VAW'(gv)),
                .nb_var   (cvar[(gv + 1 < NV) ? gv + 1 : gv]),
                .nb_coef  (ccoef[(gv + 1 < NV) ? gv + 1 : gv]),
                .var_q    (cvar[gv]),
                .coef_q   (ccoef[gv])
            );
        end
        for (gv = 0; gv < NG; gv++) begin : g_gcell
            gasl_grp_cell u_cell (
                .aclk     (aclk),
                .ctrl     (gctrl),
                .my_index (GAW'(gv)),
                .nb_gid   (cgid[(gv + 1 < NG) ? gv + 1 : gv]),
                .gid_q    (cgid[gv])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (gmem_we) begin
            gstart_mem[GAW'(gi_reg)] <= nstart_reg;
            gend_mem[GAW'(gi_reg)]   <= VCW'(32'(nstart_reg) + 32'(gsize_reg));
        end
        if (vgid_we) begin
            vgid_mem[vgid_waddr] <= GAW'(gi_reg);
        end
        gstart_rd_reg <= gstart_mem[GAW'(gi_reg)];
        gend_rd_reg   <= gend_mem[GAW'(gi_reg)];
        vgid_rd_reg   <= vgid_mem[vgid_raddr];
    end

    assign vgid_waddr = VAW'(cnt_reg);
    assign vgid_raddr = VAW'(cvar[VAW'(cnt_reg)]);

    always_comb begin
        logic [VAW-1:0] vpos;
        logic [VAW-1:0] vidx;
        vpos = VAW'(pos_reg);
        vidx = VAW'(vi_reg);

        state_next    = state_reg;
        act_next      = act_reg;
        vi_next       = vi_reg;
        pos_next      = pos_reg;
        gi_next       = gi_reg;
        gsize_next    = gsize_reg;
        coef_next     = coef_reg;
        vtot_next     = vtot_reg;
        gtot_next     = gtot_reg;
        nstart_next   = nstart_reg;
        cnt_next      = cnt_reg;
        end_next      = end_reg;
        gid_next      = gid_reg;
        vflags_next   = vflags_reg;
        gflags_next   = gflags_reg;
        status_next   = status_reg;
        rd_var_next   = rd_var_reg;
        rd_coef_next  = rd_coef_reg;
        rd_grp_next   = rd_grp_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        vctrl         = '0;
        gctrl         = '0;
        gmem_we       = 1'b0;
        vgid_we       = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next     = gasl_pkg::action_t'(s_tuser);
                    vi_next      = s_tdata[7:0];
                    pos_next     = s_tdata[15:8];
                    gi_next      = s_tdata[21:16];
                    gsize_next   = s_tdata[30:22];
                    coef_next    = s_tdata[94:31];
                    status_next  = gasl_pkg::ST_OK;
                    rd_var_next  = '0;
                    rd_coef_next = '0;
                    rd_grp_next  = '0;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                unique case (act_reg)
                    gasl_pkg::ACT_LOAD, gasl_pkg::ACT_ADD: begin
                        if (act_reg == gasl_pkg::ACT_ADD || coef_reg[62:0] != '0) begin
                            if (32'(vi_reg) >= NV) begin
                                status_next = gasl_pkg::ST_RANGE;
                            end else if (vflags_reg[vidx]) begin
                                status_next = gasl_pkg::ST_ACTIVE;
                            end else if (32'(vtot_reg) >= NV) begin
                                status_next = gasl_pkg::ST_FULL;
                            end else begin
                                vctrl.wr      = 1'b1;
                                vctrl.pos     = VAW'(vtot_reg);
                                vctrl.var_val = vi_reg;
                                vctrl.coef    = (act_reg == gasl_pkg::ACT_ADD) ? '0 : coef_reg;
                                vflags_next[vidx] = 1'b1;
                                vtot_next     = vtot_reg + 1'b1;
                            end
                        end
                    end
                    gasl_pkg::ACT_RMV: begin
                        if (32'(pos_reg) >= 32'(vtot_reg)) begin
                            status_next = gasl_pkg::ST_RANGE;
                        end else begin
                            vflags_next[VAW'(cvar[vpos])] = 1'b0;
                            vctrl.sh  = 1'b1;
                            vctrl.pos = vpos;
                            vtot_next = vtot_reg - 1'b1;
                        end
                    end
                    gasl_pkg::ACT_DEF: begin
                        if (32'(gi_reg) >= NG || gsize_reg == '0 ||
                            32'(nstart_reg) + 32'(gsize_reg) > NV) begin
                            status_next = gasl_pkg::ST_RANGE;
                        end else begin
                            gmem_we     = 1'b1;
                            cnt_next    = nstart_reg;
                            end_next    = VCW'(32'(nstart_reg) + 32'(gsize_reg));
                            nstart_next = VCW'(32'(nstart_reg) + 32'(gsize_reg));
                            state_next  = S_DEFINE;
                        end
                    end
                    gasl_pkg::ACT_GADD: begin
                        if (32'(gi_reg) >= NG) begin
                            status_next = gasl_pkg::ST_RANGE;
                        end else if (gflags_reg[GAW'(gi_reg)]) begin
                            status_next = gasl_pkg::ST_ACTIVE;
                        end else if (32'(gtot_reg) >= NG) begin
                            status_next = gasl_pkg::ST_FULL;
                        end else begin
                            gctrl.wr  = 1'b1;
                            gctrl.pos = GAW'(gtot_reg);
                            gctrl.gid = gi_reg;
                            gflags_next[GAW'(gi_reg)] = 1'b1;
                            gtot_next  = gtot_reg + 1'b1;
                            state_next = S_GFETCH;
                        end
                    end
                    gasl_pkg::ACT_GRMV: begin
                        if (32'(pos_reg) >= 32'(gtot_reg)) begin
                            status_next = gasl_pkg::ST_RANGE;
                        end else begin
                            // latch the id before the group list shifts
                            gid_next = GAW'(cgid[GAW'(pos_reg)]);
                            gflags_next[GAW'(cgid[GAW'(pos_reg)])] = 1'b0;
                            gctrl.sh  = 1'b1;
                            gctrl.pos = GAW'(pos_reg);
                            gtot_next = gtot_reg - 1'b1;
                            cnt_next  = '0;
                            if (vtot_reg != '0) begin
                                state_next = S_SCAN_A;
                            end
                        end
                    end
                    gasl_pkg::ACT_READ: begin
                        if (32'(pos_reg) < 32'(vtot_reg)) begin
                            rd_var_next  = cvar[vpos];
                            rd_coef_next = ccoef[vpos];
                        end
                        if (32'(pos_reg) < 32'(gtot_reg)) begin
                            rd_grp_next = cgid[GAW'(pos_reg)];
                        end
                        if (32'(pos_reg) >= 32'(vtot_reg) && 32'(pos_reg) >= 32'(gtot_reg)) begin
                            status_next = gasl_pkg::ST_RANGE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DEFINE: begin
                vgid_we  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 >= end_reg) begin
                    state_next = S_DONE;
                end
            end
            S_GFETCH: begin
                cnt_next = gstart_rd_reg;
                end_next = gend_rd_reg;
                state_next = (gstart_rd_reg < gend_rd_reg) ? S_GADD : S_DONE;
            end
            S_GADD: begin
                if (!vflags_reg[VAW'(cnt_reg)] && 32'(vtot_reg) < NV) begin
                    vctrl.wr      = 1'b1;
                    vctrl.pos     = VAW'(vtot_reg);
                    vctrl.var_val = gasl_pkg::VAR_W'(cnt_reg);
                    vctrl.coef    = '0;
                    vflags_next[VAW'(cnt_reg)] = 1'b1;
                    vtot_next     = vtot_reg + 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 >= end_reg) begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_A: begin
                // tag lookup of the variable in the current slot
                state_next = S_SCAN_B;
            end
            S_SCAN_B: begin
                if (vgid_rd_reg == gid_reg) begin
                    vflags_next[VAW'(cvar[VAW'(cnt_reg)])] = 1'b0;
                    vctrl.sh  = 1'b1;
                    vctrl.pos = VAW'(cnt_reg);
                    vtot_next = vtot_reg - 1'b1;
                    state_next = (cnt_reg + 1'b1 < vtot_reg) ? S_SCAN_A : S_DONE;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = (cnt_reg + 1'b1 < vtot_reg) ? S_SCAN_A : S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {
                        (32'(gi_reg) < NG) ? gflags_reg[GAW'(gi_reg)] : 1'b0,
                        (32'(vi_reg) < NV) ? vflags_reg[vidx] : 1'b0,
                        rd_grp_reg, rd_coef_reg, rd_var_reg,
                        7'(gtot_reg), 9'(vtot_reg)
                    };
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            vtot_reg     <= '0;
            gtot_reg     <= '0;
            nstart_reg   <= '0;
            vflags_reg   <= '0;
            gflags_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vtot_reg     <= vtot_next;
            gtot_reg     <= gtot_next;
            nstart_reg   <= nstart_next;
            vflags_reg   <= vflags_next;
            gflags_reg   <= gflags_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        act_reg     <= act_next;
        vi_reg      <= vi_next;
        pos_reg     <= pos_next;
        gi_reg      <= gi_next;
        gsize_reg   <= gsize_next;
        coef_reg    <= coef_next;
        cnt_reg     <= cnt_next;
        end_reg     <= end_next;
        gid_reg     <= gid_next;
        status_reg  <= status_next;
        rd_var_reg  <= rd_var_next;
        rd_coef_reg <= rd_coef_next;
        rd_grp_reg  <= rd_grp_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `GASL_ASSERT(a_var_flags_match_count, aclk, aresetn, $countones(vflags_reg) == 32'(vtot_reg), "variable flags disagree with list count")
    `GASL_ASSERT(a_grp_flags_match_count, aclk, aresetn, $countones(gflags_reg) == 32'(gtot_reg), "group flags disagree with group count")
    `GASL_ASSERT(a_scan_in_list, aclk, aresetn, (state_reg == S_SCAN_A || state_reg == S_SCAN_B) |-> cnt_reg < vtot_reg, "group removal scan ran past the list")
    `GASL_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid_reg && state_reg == S_IDLE, "reset left a result or busy sequencer")
endmodule

// ===== src/gasl_var_cell.sv =====
// one slot of the active variable list: variable index and coefficient word
module gasl_var_cell (
    input  logic                       aclk,
    input  gasl_pkg::vctrl_t           ctrl,
    input  logic [gasl_pkg::VAR_AW-1:0] my_index,
    input  logic [gasl_pkg::VAR_W-1:0]  nb_var,
    input  logic [gasl_pkg::COEF_W-1:0] nb_coef,
    output logic [gasl_pkg::VAR_W-1:0]  var_q,
    output logic [gasl_pkg::COEF_W-1:0] coef_q
);
    logic [gasl_pkg::VAR_W-1:0]  var_reg;
    logic [gasl_pkg::COEF_W-1:0] coef_reg;

    // append lands at the tail slot, remove pulls from the upper neighbor
    always_ff @(posedge aclk) begin
        if (ctrl.wr && ctrl.pos == my_index) begin
            var_reg  <= ctrl.var_val;
            coef_reg <= ctrl.coef;
        end else if (ctrl.sh && my_index >= ctrl.pos) begin
            var_reg  <= nb_var;
            coef_reg <= nb_coef;
        end
    end

    assign var_q  = var_reg;
    assign coef_q = coef_reg;
endmodule

// ===== src/gasl_grp_cell.sv =====
// one slot of the active group list
module gasl_grp_cell (
    input  logic                        aclk,
    input  gasl_pkg::gctrl_t            ctrl,
    input  logic [gasl_pkg::GRP_AW-1:0] my_index,
    input  logic [gasl_pkg::GRP_W-1:0]  nb_gid,
    output logic [gasl_pkg::GRP_W-1:0]  gid_q
);
    logic [gasl_pkg::GRP_W-1:0] gid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr && ctrl.pos == my_index) begin
            gid_reg <= ctrl.gid;
        end else if (ctrl.sh && my_index >= ctrl.pos) begin
            gid_reg <= nb_gid;
        end
    end

    assign gid_q = gid_reg;
endmodule

// ===== verif/tb_grouped_active_set_list.sv =====
// self-checking testbench of the grouped active set list
module tb_grouped_active_set_list;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        gasl_pkg::status_t status;
        logic [8:0]  active_count;
        logic [6:0]  group_count;
        logic [7:0]  var_at;
        logic [63:0] coef_at;
        logic [5:0]  group_at;
        logic        var_flag;
        logic        group_flag;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [2:0]  s_tuser = gasl_pkg::ACT_NOP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;

    grouped_active_set_list u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the list state
    logic [7:0]  sh_vars   [gasl_pkg::MAX_VARS];
    logic [63:0] sh_coefs  [gasl_pkg::MAX_VARS];
    logic        sh_vflag  [gasl_pkg::MAX_VARS];
    logic [5:0]  sh_vtag   [gasl_pkg::MAX_VARS];
    logic        sh_tagged [gasl_pkg::MAX_VARS];
    logic [5:0]  sh_groups [gasl_pkg::MAX_GROUPS];
    logic        sh_gflag  [gasl_pkg::MAX_GROUPS];
    logic        sh_gdef   [gasl_pkg::MAX_GROUPS];
    int          sh_gstart [gasl_pkg::MAX_GROUPS];
    int          sh_gend   [gasl_pkg::MAX_GROUPS];
    int          var_total, group_total, next_start;

    list_result_t pending_results[$];
    int  errors = 0;
    bit  no_idle = 1'b0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_cycles = 0;

    function automatic gasl_pkg::status_t add_var(int v, logic [63:0] c);
        if (sh_vflag[v]) return gasl_pkg::ST_ACTIVE;
        if (var_total >= gasl_pkg::MAX_VARS) return gasl_pkg::ST_FULL;
        sh_vars[var_total] = v[7:0];
        sh_coefs[var_total] = c;
        sh_vflag[v] = 1'b1;
        var_total++;
        return gasl_pkg::ST_OK;
    endfunction

    function automatic void predict_list(gasl_pkg::action_t act, logic [7:0] vi,
                                         logic [7:0] pos, logic [5:0] gi, logic [8:0] gs,
                                         logic [63:0] cf);
        list_result_t r;
        int g, k;
        r = '{gasl_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0};
        unique case (act)
            gasl_pkg::ACT_LOAD: if (cf[62:0] != 0) r.status = add_var(vi, cf);
            gasl_pkg::ACT_ADD: r.status = add_var(vi, 64'd0);
            gasl_pkg::ACT_RMV: begin
                if (pos >= var_total) r.status = gasl_pkg::ST_RANGE;
                else begin
                    sh_vflag[sh_vars[pos]] = 1'b0;
                    for (int i = pos; i + 1 < var_total; i++) begin
                        sh_vars[i] = sh_vars[i+1];
                        sh_coefs[i] = sh_coefs[i+1];
                    end
                    var_total--;
                end
            end
            gasl_pkg::ACT_DEF: begin
                if (gs == 0 || next_start + gs > gasl_pkg::MAX_VARS) r.status = gasl_pkg::ST_RANGE;
                else begin
                    sh_gstart[gi] = next_start;
                    sh_gend[gi] = next_start + gs;
                    sh_gdef[gi] = 1'b1;
                    for (int i = next_start; i < next_start + gs; i++) begin
                        sh_vtag[i] = gi;
                        sh_tagged[i] = 1'b1;
                    end
                    next_start += gs;
                end
            end
            gasl_pkg::ACT_GADD: begin
                if (sh_gflag[gi]) r.status = gasl_pkg::ST_ACTIVE;
                else if (group_total >= gasl_pkg::MAX_GROUPS) r.status = gasl_pkg::ST_FULL;
                else begin
                    sh_groups[group_total] = gi;
                    sh_gflag[gi] = 1'b1;
                    group_total++;
                    for (int i = sh_gstart[gi]; i < sh_gend[gi] && i < gasl_pkg::MAX_VARS; i++)
                        if (!sh_vflag[i] && var_total < gasl_pkg::MAX_VARS)
                            void'(add_var(i, 64'd0));
                end
            end
            gasl_pkg::ACT_GRMV: begin
                if (pos >= group_total) r.status = gasl_pkg::ST_RANGE;
                else begin
                    // group id is latched before the list shifts
                    g = sh_groups[pos];
                    sh_gflag[g] = 1'b0;
                    for (int i = pos; i + 1 < group_total; i++) sh_groups[i] = sh_groups[i+1];
                    group_total--;
                    k = 0;
                    for (int i = 0; i < var_total; i++) begin
                        if (sh_vtag[sh_vars[i]] == g) sh_vflag[sh_vars[i]] = 1'b0;
                        else begin
                            sh_vars[k] = sh_vars[i];
                            sh_coefs[k] = sh_coefs[i];
                            k++;
                        end
                    end
                    var_total = k;
                end
            end
            gasl_pkg::ACT_READ: begin
                if (pos < var_total) begin
                    r.var_at = sh_vars[pos];
                    r.coef_at = sh_coefs[pos];
                end
                if (pos < group_total) r.group_at = sh_groups[pos];
                if (pos >= var_total && pos >= group_total) r.status = gasl_pkg::ST_RANGE;
            end
            default: ;
        endcase
        r.active_count = 9'(var_total);
        r.group_count = 7'(group_total);
        r.var_flag = sh_vflag[vi];
        r.group_flag = sh_gflag[gi];
        pending_results.push_back(r);
    endfunction

    task automatic send_item(gasl_pkg::action_t act, logic [7:0] vi, logic [7:0] pos,
                             logic [5:0] gi, logic [8:0] gs, logic [63:0] cf);
        int gap;
        gap = 0;
        if (!no_idle) while ($urandom_range(99) < 29 && gap < 6) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, cf, gs, gi, pos, vi};
        do @(posedge aclk); while (!s_tready);
        predict_list(act, vi, pos, gi, gs, cf);
    endtask

    function automatic bit all_tagged();
        for (int i = 0; i < var_total; i++)
            if (!sh_tagged[sh_vars[i]]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_random();
        gasl_pkg::action_t act;
        logic [7:0] vi, pos;
        logic [5:0] gi;
        logic [8:0] gs;
        logic [63:0] cf;
        int r;
        r = $urandom_range(99);
        vi = (next_start > 0 && $urandom_range(9) != 0) ? 8'($urandom_range(next_start - 1))
                                                       : 8'($urandom);
        pos = (var_total > 0 && $urandom_range(3) != 0) ? 8'($urandom_range(var_total - 1))
                                                       : 8'($urandom);
        gi = 6'($urandom);
        gs = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(4, 1));
        cf = {$urandom, $urandom};
        if ($urandom_range(9) == 0) cf = $urandom_range(1) ? 64'd0 : 64'h8000_0000_0000_0000;
        if (r < 22) act = gasl_pkg::ACT_LOAD;
        else if (r < 37) act = gasl_pkg::ACT_ADD;
        else if (r < 52) act = gasl_pkg::ACT_RMV;
        else if (r < 57) act = gasl_pkg::ACT_DEF;
        else if (r < 67) act = gasl_pkg::ACT_GADD;
        else if (r < 80) act = gasl_pkg::ACT_GRMV;
        else if (r < 97) act = gasl_pkg::ACT_READ;
        else act = gasl_pkg::ACT_NOP;
        if (act == gasl_pkg::ACT_GADD) begin
            // only defined groups may be appended
            for (int t = 0; t < 16 && !sh_gdef[gi]; t++) gi = 6'($urandom);
            if (!sh_gdef[gi]) act = gasl_pkg::ACT_DEF;
        end
        if (act == gasl_pkg::ACT_GRMV) begin
            if (!all_tagged()) act = gasl_pkg::ACT_READ;
            else if (group_total > 0 && $urandom_range(4) != 0)
                pos = 8'($urandom_range(group_total - 1));
        end
        send_item(act, vi, pos, gi, gs, cf);
    endtask

    // receiver side, with a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_cycles <= 300;
            m_tready    <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else m_tready <= no_idle || ($urandom_range(99) >= 29);
    end

    always @(posedge aclk) begin
        list_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%t unexpected transaction status=%0d data=%h", $realtime,
                         m_tuser, m_tdata);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if ({e.group_flag, e.var_flag, e.group_at, e.coef_at, e.var_at,
                     e.group_count, e.active_count} !== m_tdata || e.status !== m_tuser) begin
                    $display({"%t mismatch: expected status=%0d cnt=%0d gcnt=%0d var=%0d",
                              " coef=%h grp=%0d vf=%b gf=%b"},
                             $realtime, e.status, e.active_count, e.group_count, e.var_at,
                             e.coef_at, e.group_at, e.var_flag, e.group_flag);
                    $display({"%t          actual   status=%0d cnt=%0d gcnt=%0d var=%0d",
                              " coef=%h grp=%0d vf=%b gf=%b"},
                             $realtime, m_tuser, m_tdata[8:0], m_tdata[15:9], m_tdata[23:16],
                             m_tdata[87:24], m_tdata[93:88], m_tdata[94], m_tdata[95]);
                    errors++;
                end
            end
        end
    end

    task automatic test_var_ops();
        send_item(gasl_pkg::ACT_LOAD, 8'd5, 8'd0, 6'd0, 9'd0, 64'h3FF0_0000_0000_0000);
        send_item(gasl_pkg::ACT_LOAD, 8'd5, 8'd0, 6'd0, 9'd0, 64'h4000_0000_0000_0000);
        send_item(gasl_pkg::ACT_LOAD, 8'd6, 8'd0, 6'd0, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_LOAD, 8'd6, 8'd0, 6'd0, 9'd0, 64'h8000_0000_0000_0000);
        send_item(gasl_pkg::ACT_ADD, 8'd6, 8'd0, 6'd0, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_ADD, 8'd6, 8'd0, 6'd0, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_LOAD, 8'd200, 8'd0, 6'd0, 9'd0, '1);
        send_item(gasl_pkg::ACT_READ, 8'd255, 8'd0, 6'd63, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_READ, 8'd0, 8'd2, 6'd0, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_READ, 8'd0, 8'd255, 6'd0, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_RMV, 8'd0, 8'd5, 6'd0, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_RMV, 8'd0, 8'd0, 6'd0, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_NOP, 8'd6, 8'd0, 6'd0, 9'd0, 64'd0);
    endtask

    task automatic test_group_ops();
        send_item(gasl_pkg::ACT_DEF, 8'd0, 8'd0, 6'd0, 9'd4, 64'd0);
        send_item(gasl_pkg::ACT_DEF, 8'd0, 8'd0, 6'd1, 9'd8, 64'd0);
        send_item(gasl_pkg::ACT_DEF, 8'd0, 8'd0, 6'd0, 9'd4, 64'd0);
        send_item(gasl_pkg::ACT_DEF, 8'd0, 8'd0, 6'd2, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_DEF, 8'd0, 8'd0, 6'd2, 9'd256, 64'd0);
        send_item(gasl_pkg::ACT_DEF, 8'd0, 8'd0, 6'd2, 9'd200, 64'd0);
        send_item(gasl_pkg::ACT_DEF, 8'd0, 8'd0, 6'd63, 9'd1, 64'd0);
        send_item(gasl_pkg::ACT_GADD, 8'd0, 8'd0, 6'd1, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_GADD, 8'd0, 8'd0, 6'd1, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_GADD, 8'd0, 8'd0, 6'd0, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_GADD, 8'd0, 8'd0, 6'd63, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_READ, 8'd0, 8'd1, 6'd0, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_GRMV, 8'd0, 8'd9, 6'd0, 9'd0, 64'd0);
        send_item(gasl_pkg::ACT_GRMV, 8'd0, 8'd0, 6'd1, 9'd0, 64'd0);
    endtask

    task automatic test_random(int n);
        repeat (n) send_random();
    endtask

    task automatic test_back_to_back(int n);
        no_idle = 1'b1;
        repeat (n) send_random();
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        hold_req++;
        repeat (30) send_random();
    endtask

    initial begin
        for (int i = 0; i < gasl_pkg::MAX_VARS; i++) begin
            sh_vflag[i] = 1'b0;
            sh_tagged[i] = 1'b0;
            sh_vtag[i] = '0;
        end
        for (int i = 0; i < gasl_pkg::MAX_GROUPS; i++) begin
            sh_gflag[i] = 1'b0;
            sh_gdef[i] = 1'b0;
            sh_gstart[i] = 0;
            sh_gend[i] = 0;
        end
        var_total = 0;
        group_total = 0;
        next_start = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_var_ops();
        test_group_ops();
        test_random(300);
        test_back_to_back(100);
        test_output_stall();
        test_random(200);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("** grouped_active_set_list: PASSED **");
        else $display("** grouped_active_set_list: FAILED **");
        $finish;
    end

    initial begin
        #20ms;
        $display("** grouped_active_set_list: FAILED **");
        $finish;
    end
endmodule

// ===== grouped_active_set_list.f =====
+incdir+src
src/gasl_pkg.sv
src/gasl_var_cell.sv
src/gasl_grp_cell.sv
src/grouped_active_set_list.sv
verif/tb_grouped_active_set_list.sv
